@@ hw/rtl/sla_pkg.sv @@
// Shared constants and types for the serial line assembler.
package sla_pkg;

  // Field widths.
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CFG_W  = 6;

  // Line terminators.
  localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'd0;

  // Reset value of the character limit register.
  localparam logic [CFG_W-1:0] MAX_CHARS_RESET = 6'd63;

  // One result item as held in the output register.
  typedef struct packed {
    logic [CHAR_W-1:0] line_char;
    logic              empty_line;
    logic              line_last;
  } out_item_t;

endpackage

@@ hw/rtl/sla_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module sla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/serial_line_assembler.sv @@
// Serial line assembler: collects received bytes into a line and streams it out.
// A data byte is accepted in the idle state; the block is ready again in the next cycle.
// On a terminator the walk reads entry zero into a holding register, then moves each
// held character to the output register once the next entry shows if it is last,
// one per cycle while out_tready is high. Input is held off meanwhile.
// Synchronous active-low reset clears the count and control; no clearing pass.
module serial_line_assembler #(
  parameter int unsigned LINE_CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration: max_chars.
  input  logic                        cfg_wr_en,
  input  logic [sla_pkg::CFG_W-1:0]   cfg_wr_data,
  // Input stream. tdata: rx_byte[7:0].
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sla_pkg::CHAR_W-1:0]  in_tdata,
  // Result stream. tdata: line_char[7:0]. tuser: empty_line[0].
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sla_pkg::CHAR_W-1:0]  out_tdata,
  output logic                        out_tuser,
  output logic                        out_tlast
);

  localparam int unsigned AW = $clog2(LINE_CAPACITY);
  localparam int unsigned CW = (AW > sla_pkg::CFG_W) ? AW : sla_pkg::CFG_W;
  localparam logic [AW-1:0] COUNT_MAX = AW'(LINE_CAPACITY - 1);

  typedef enum logic {ST_IDLE, ST_RD} state_t;

  state_t                     state_r, state_nxt;
  logic [sla_pkg::CFG_W-1:0]  max_chars_r, max_chars_nxt;
  logic [AW-1:0]              count_r, count_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;
  logic [AW-1:0]              limit_r, limit_nxt;
  logic [sla_pkg::CHAR_W-1:0] pend_r, pend_nxt;
  logic                       out_valid_r, out_valid_nxt;
  sla_pkg::out_item_t         out_item_r, out_item_nxt;

  logic                       in_acc;
  logic                       is_term;
  logic                       out_free;
  logic                       line_end;
  logic [CW-1:0]              mc_ext, cnt_ext, limit_sel;
  logic                       wr_en;
  logic [sla_pkg::CHAR_W-1:0] rd_data;

  // Line memory: written at the fill count, read at the next walk index.
  sla_ram #(
    .WIDTH (sla_pkg::CHAR_W),
    .DEPTH (LINE_CAPACITY)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r),
    .wr_data (in_tdata),
    .rd_addr (idx_nxt),
    .rd_data (rd_data)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_term   = (in_tdata == sla_pkg::CHAR_LF) || (in_tdata == sla_pkg::CHAR_CR);
  assign wr_en     = in_acc && !is_term && (count_r < COUNT_MAX);
  assign out_free  = !out_valid_r || out_tready;

  // Characters to hand out before the zero-byte check: min(count, max_chars).
  assign mc_ext    = CW'(max_chars_r);
  assign cnt_ext   = CW'(count_r);
  assign limit_sel = (mc_ext < cnt_ext) ? mc_ext : cnt_ext;

  // The walk ends at the limit or at a stored zero byte.
  assign line_end  = (idx_r == limit_r) || (rd_data == sla_pkg::CHAR_NUL);

  // Next-state logic: fill the line, then walk it one entry per cycle while the output register is free.
  always_comb begin
    state_nxt     = state_r;
    max_chars_nxt = max_chars_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    limit_nxt     = limit_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_item_nxt  = out_item_r;

    if (cfg_wr_en) begin
      max_chars_nxt = cfg_wr_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_acc) begin
          if (!is_term) begin
            if (count_r < COUNT_MAX) begin
              count_nxt = count_r + 1'b1;
            end
          end else if (count_r != '0) begin
            limit_nxt = limit_sel[AW-1:0];
            count_nxt = '0;
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        if (out_free) begin
          if (idx_r == '0) begin
            if (line_end) begin
              // Nothing survives truncation: one empty-line result.
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{line_char: sla_pkg::CHAR_NUL, empty_line: 1'b1,
                                line_last: 1'b1};
              state_nxt     = ST_IDLE;
            end else begin
              pend_nxt = rd_data;
              idx_nxt  = idx_r + 1'b1;
            end
          end else begin
            // Emit the held character once the next entry tells if it is last.
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{line_char: pend_r, empty_line: 1'b0, line_last: line_end};
            if (line_end) begin
              state_nxt = ST_IDLE;
            end else begin
              pend_nxt = rd_data;
              idx_nxt  = idx_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_chars_r <= sla_pkg::MAX_CHARS_RESET;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_chars_r <= max_chars_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      limit_r     <= limit_nxt;
      pend_r      <= pend_nxt;
      out_item_r  <= out_item_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r.line_char;
  assign out_tuser  = out_item_r.empty_line;
  assign out_tlast  = out_item_r.line_last;

`ifndef SYNTH
  // The fill count never passes the last usable entry.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_MAX)
    else $error("line count beyond capacity");

  // A terminator on a non-empty line starts the walk with the count cleared.
  a_term_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_term && (count_r != '0)) |=> (state_r == ST_RD) && (count_r == '0))
    else $error("terminator did not start line walk");

  // The walk index never passes the limit taken at the terminator.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (idx_r <= limit_r))
    else $error("walk index beyond limit");

  // An empty-line result is always the last one and carries a zero character.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.empty_line) |->
      (out_item_r.line_last && (out_item_r.line_char == sla_pkg::CHAR_NUL)))
    else $error("malformed empty-line result");
`endif

endmodule
